// ----- sv/rnu_pkg.sv -----
// Shared types and constants for the rotating nearest-neighbor upscaler.
package rnu_pkg;

   localparam int STORE_AW    = 14;
   localparam int COORD_W     = 8;
   localparam int DIM_W       = 9;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   localparam int MODE_BORDER = 2;
   localparam int MODE_RGB565 = 3;

   typedef enum logic [1:0] {
      OP_PIXEL_WRITE,
      OP_COL_WRITE,
      OP_ROW_WRITE,
      OP_RENDER
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_PIX_WRITE,
      KIND_COL_WRITE,
      KIND_ROW_WRITE,
      KIND_RENDER_IMG,
      KIND_RENDER_BORDER
   } kind_type;

   typedef enum logic [2:0] {
      REG_SOURCE_WIDTH,
      REG_SOURCE_HEIGHT,
      REG_WINDOW_LEFT,
      REG_WINDOW_TOP,
      REG_WINDOW_WIDTH,
      REG_WINDOW_HEIGHT,
      REG_MODE_BITS,
      REG_BACKGROUND
   } reg_index_type;

   typedef struct packed {
      logic [7:0]  source_width;
      logic [7:0]  source_height;
      logic [9:0]  window_left;
      logic [9:0]  window_top;
      logic [10:0] window_width;
      logic [10:0] window_height;
      logic [3:0]  mode_bits;
      logic [23:0] background_color;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [13:0] store_index;
      logic [23:0] color;
      logic [6:0]  map_value;
      logic [9:0]  col_idx;
      logic [9:0]  row_idx;
      logic [9:0]  dest_col;
      logic [9:0]  dest_row;
   } item_type;

endpackage

// ----- sv/rotating_nearest_upscaler.sv -----
// Rotating nearest-neighbor upscaler: register file and block top level.
//
// Requests arrive on the req_ channel (valid/ready). Opcodes load the source
// image store and the column and row maps, or render one destination pixel.
// A render request on the display yields one result on the rsp_ channel
// (valid/ready) when the pixel lies inside the image window, or when it lies
// outside and border fill is on; write requests and dropped pixels yield none.
// Registers sit on the csr_ APB port, one per word; users must write them
// only while idle; the block does not enforce it. Responses are registered.
// Throughput: one request per clock, set by one access per clock on each
// map memory and on the image store, each in its own pipeline stage.
// When rsp_ready is low with a result held, the render pipeline freezes; a
// 4-entry queue keeps taking requests until it fills, then req_ready drops.
// Reset empties the queue and pipeline and loads the register defaults
// (128 x 128 source, 720 x 720 window at the origin, mode and color zero).
// Image store and map contents are undefined until written.
module rotating_nearest_upscaler import rnu_pkg::*; #(
   parameter int SRC_MAX_DIM = 128,
   parameter int DEST_WIDTH  = 720,
   parameter int DEST_HEIGHT = 720,
   parameter int MAP_DEPTH   = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [13:0] req_store_index,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic [6:0]  req_map_value,
   input  logic [9:0]  req_dest_col,
   input  logic [9:0]  req_dest_row,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_pixel_color,
   output logic        rsp_is_border,
   output logic [9:0]  rsp_out_col,
   output logic [9:0]  rsp_out_row,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type       cfg_ff;
   reg_index_type reg_index;
   logic          csr_write;
   item_type      front_item;
   logic          front_keep;
   logic          queue_full;
   logic          pop_valid;
   logic          pop_ready;
   item_type      pop_item;

   assign csr_pready = 1'b1;
   assign reg_index  = reg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width     <= 8'd128;
         cfg_ff.source_height    <= 8'd128;
         cfg_ff.window_left      <= '0;
         cfg_ff.window_top       <= '0;
         cfg_ff.window_width     <= 11'd720;
         cfg_ff.window_height    <= 11'd720;
         cfg_ff.mode_bits        <= '0;
         cfg_ff.background_color <= '0;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_SOURCE_WIDTH:  cfg_ff.source_width     <= csr_pwdata[7:0];
            REG_SOURCE_HEIGHT: cfg_ff.source_height    <= csr_pwdata[7:0];
            REG_WINDOW_LEFT:   cfg_ff.window_left      <= csr_pwdata[9:0];
            REG_WINDOW_TOP:    cfg_ff.window_top       <= csr_pwdata[9:0];
            REG_WINDOW_WIDTH:  cfg_ff.window_width     <= csr_pwdata[10:0];
            REG_WINDOW_HEIGHT: cfg_ff.window_height    <= csr_pwdata[10:0];
            REG_MODE_BITS:     cfg_ff.mode_bits        <= csr_pwdata[3:0];
            REG_BACKGROUND:    cfg_ff.background_color <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_SOURCE_WIDTH:  csr_prdata = {24'd0, cfg_ff.source_width};
         REG_SOURCE_HEIGHT: csr_prdata = {24'd0, cfg_ff.source_height};
         REG_WINDOW_LEFT:   csr_prdata = {22'd0, cfg_ff.window_left};
         REG_WINDOW_TOP:    csr_prdata = {22'd0, cfg_ff.window_top};
         REG_WINDOW_WIDTH:  csr_prdata = {21'd0, cfg_ff.window_width};
         REG_WINDOW_HEIGHT: csr_prdata = {21'd0, cfg_ff.window_height};
         REG_MODE_BITS:     csr_prdata = {28'd0, cfg_ff.mode_bits};
         REG_BACKGROUND:    csr_prdata = {8'd0, cfg_ff.background_color};
         default:           csr_prdata = '0;
      endcase
   end

   assign req_ready = !queue_full;

   rnu_front #(
      .DEST_WIDTH  (DEST_WIDTH),
      .DEST_HEIGHT (DEST_HEIGHT),
      .MAP_DEPTH   (MAP_DEPTH)
   ) u_front (
      .cfg             (cfg_ff),
      .req_opcode      (req_opcode),
      .req_store_index (req_store_index),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .req_map_value   (req_map_value),
      .req_dest_col    (req_dest_col),
      .req_dest_row    (req_dest_row),
      .item            (front_item),
      .keep            (front_keep)
   );

   rnu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid && front_keep),
      .push_item  (front_item),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   rnu_back #(
      .SRC_MAX_DIM (SRC_MAX_DIM),
      .MAP_DEPTH   (MAP_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .pop_valid       (pop_valid),
      .pop_item        (pop_item),
      .pop_ready       (pop_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_is_border   (rsp_is_border),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_row     (rsp_out_row)
   );

endmodule

// ----- sv/rnu_front.sv -----
// Front end: classifies each request and works out its map indices.
module rnu_front import rnu_pkg::*; #(
   parameter int DEST_WIDTH  = 720,
   parameter int DEST_HEIGHT = 720,
   parameter int MAP_DEPTH   = 1024
) (
   input  cfg_type     cfg,
   input  logic [1:0]  req_opcode,
   input  logic [13:0] req_store_index,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic [6:0]  req_map_value,
   input  logic [9:0]  req_dest_col,
   input  logic [9:0]  req_dest_row,
   output item_type    item,
   output logic        keep
);

   logic        on_display;
   logic        map_in_range;
   logic        in_window;
   logic [11:0] col_end;
   logic [11:0] row_end;
   logic [10:0] local_col;
   logic [10:0] local_row;
   logic [10:0] lx;
   logic [10:0] ly;
   logic        swap_axes;

   assign on_display = ({1'b0, req_dest_col} < 11'(DEST_WIDTH)) &&
                       ({1'b0, req_dest_row} < 11'(DEST_HEIGHT));
   assign map_in_range = req_store_index < 14'(MAP_DEPTH);

   assign col_end = {2'b0, cfg.window_left} + {1'b0, cfg.window_width};
   assign row_end = {2'b0, cfg.window_top} + {1'b0, cfg.window_height};
   assign in_window = (req_dest_col >= cfg.window_left) && ({2'b0, req_dest_col} < col_end) &&
                      (req_dest_row >= cfg.window_top) && ({2'b0, req_dest_row} < row_end);

   assign local_col = {1'b0, req_dest_col} - {1'b0, cfg.window_left};
   assign local_row = {1'b0, req_dest_row} - {1'b0, cfg.window_top};
   // past the end of the maps, read the last entry
   assign lx = (local_col >= 11'(MAP_DEPTH)) ? 11'(MAP_DEPTH - 1) : local_col;
   assign ly = (local_row >= 11'(MAP_DEPTH)) ? 11'(MAP_DEPTH - 1) : local_row;

   assign swap_axes = (cfg.mode_bits[1:0] == ROT_90) || (cfg.mode_bits[1:0] == ROT_270);

   always_comb begin
      item.store_index = req_store_index;
      item.color       = {req_red_in, req_green_in, req_blue_in};
      item.map_value   = req_map_value;
      item.col_idx     = swap_axes ? ly[9:0] : lx[9:0];
      item.row_idx     = swap_axes ? lx[9:0] : ly[9:0];
      item.dest_col    = req_dest_col;
      item.dest_row    = req_dest_row;
      item.kind        = KIND_PIX_WRITE;
      keep             = 1'b0;
      unique case (opcode_type'(req_opcode))
         OP_PIXEL_WRITE: begin
            item.kind = KIND_PIX_WRITE;
            keep      = 1'b1;
         end
         OP_COL_WRITE: begin
            item.kind = KIND_COL_WRITE;
            keep      = map_in_range;
         end
         OP_ROW_WRITE: begin
            item.kind = KIND_ROW_WRITE;
            keep      = map_in_range;
         end
         OP_RENDER: begin
            item.kind = in_window ? KIND_RENDER_IMG : KIND_RENDER_BORDER;
            // drop off-display pixels and border pixels with fill off
            keep      = on_display && (in_window || cfg.mode_bits[MODE_BORDER]);
         end
         default: begin
            item.kind = KIND_PIX_WRITE;
            keep      = 1'b0;
         end
      endcase
   end

endmodule

// ----- sv/rnu_queue.sv -----
// Short request queue between the front end and the render pipeline.
module rnu_queue import rnu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  item_type push_item,
   output logic     full,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type              entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff;
   logic [QUEUE_AW:0]     count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full      = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entries_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- sv/rnu_back.sv -----
// Render pipeline: map lookup, clamp and mirror, address, image read, format.
module rnu_back import rnu_pkg::*; #(
   parameter int SRC_MAX_DIM = 128,
   parameter int MAP_DEPTH   = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        pop_valid,
   input  item_type    pop_item,
   output logic        pop_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_pixel_color,
   output logic        rsp_is_border,
   output logic [9:0]  rsp_out_col,
   output logic [9:0]  rsp_out_row
);

   localparam int               MAP_AW  = $clog2(MAP_DEPTH);
   localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(SRC_MAX_DIM);

   logic [6:0]  col_map_mem [MAP_DEPTH];
   logic [6:0]  row_map_mem [MAP_DEPTH];
   logic [23:0] store_mem   [2**STORE_AW];

   logic                advance;
   logic [DIM_W-1:0]    w_eff;
   logic [DIM_W-1:0]    h_eff;
   logic                mirror_x;
   logic                mirror_y;

   logic                s1_valid_ff;
   item_type            s1_item_ff;
   logic [6:0]          col_rd_ff;
   logic [6:0]          row_rd_ff;

   logic                s2_valid_ff;
   item_type            s2_item_ff;
   logic [DIM_W-1:0]    x_clamp;
   logic [DIM_W-1:0]    y_clamp;
   logic [DIM_W-1:0]    x_mirror;
   logic [DIM_W-1:0]    y_mirror;
   logic [COORD_W-1:0]  sx_ff;
   logic [COORD_W-1:0]  sy_ff;

   logic                s3_valid_ff;
   item_type            s3_item_ff;
   logic [16:0]         row_base;
   logic [17:0]         pix_addr;
   logic [STORE_AW-1:0] addr_in;
   logic [STORE_AW-1:0] addr_ff;

   logic                s4_valid_ff;
   item_type            s4_item_ff;
   logic [23:0]         store_rd_ff;

   logic                s4_is_render;
   logic [23:0]         color_sel;
   logic [23:0]         color_fmt;
   logic                rsp_valid_in;
   logic                rsp_valid_ff;
   logic [23:0]         rsp_color_ff;
   logic                rsp_border_ff;
   logic [9:0]          rsp_col_ff;
   logic [9:0]          rsp_row_ff;

   // the whole pipeline moves only when the output register can take a result
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign pop_ready = advance;

   assign w_eff = (cfg.source_width == '0) ? DIM_W'(1) :
                  ({1'b0, cfg.source_width} > MAX_DIM) ? MAX_DIM : {1'b0, cfg.source_width};
   assign h_eff = (cfg.source_height == '0) ? DIM_W'(1) :
                  ({1'b0, cfg.source_height} > MAX_DIM) ? MAX_DIM : {1'b0, cfg.source_height};

   assign mirror_x = (cfg.mode_bits[1:0] == ROT_180) || (cfg.mode_bits[1:0] == ROT_270);
   assign mirror_y = (cfg.mode_bits[1:0] == ROT_90)  || (cfg.mode_bits[1:0] == ROT_180);

   // stage 1: map writes and map reads
   always_ff @(posedge clock) begin
      if (advance) begin
         if (pop_valid && (pop_item.kind == KIND_COL_WRITE)) begin
            col_map_mem[pop_item.store_index[MAP_AW-1:0]] <= pop_item.map_value;
         end
         col_rd_ff <= col_map_mem[pop_item.col_idx[MAP_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (pop_valid && (pop_item.kind == KIND_ROW_WRITE)) begin
            row_map_mem[pop_item.store_index[MAP_AW-1:0]] <= pop_item.map_value;
         end
         row_rd_ff <= row_map_mem[pop_item.row_idx[MAP_AW-1:0]];
      end
   end

   // stage 2: clamp to the source size, then mirror
   assign x_clamp  = ({2'b0, col_rd_ff} >= w_eff) ? (w_eff - 1'b1) : {2'b0, col_rd_ff};
   assign y_clamp  = ({2'b0, row_rd_ff} >= h_eff) ? (h_eff - 1'b1) : {2'b0, row_rd_ff};
   assign x_mirror = mirror_x ? (w_eff - 1'b1 - x_clamp) : x_clamp;
   assign y_mirror = mirror_y ? (h_eff - 1'b1 - y_clamp) : y_clamp;

   // stage 3: pixel address, wrapping over the store; pixel writes use their store index
   assign row_base = sy_ff * w_eff;
   assign pix_addr = {1'b0, row_base} + 18'(sx_ff);
   assign addr_in  = (s2_item_ff.kind == KIND_PIX_WRITE) ? s2_item_ff.store_index :
                     pix_addr[STORE_AW-1:0];

   // stage 4: image store access
   always_ff @(posedge clock) begin
      if (advance) begin
         if (s3_valid_ff && (s3_item_ff.kind == KIND_PIX_WRITE)) begin
            store_mem[addr_ff] <= s3_item_ff.color;
         end
         store_rd_ff <= store_mem[addr_ff];
      end
   end

   // output: pick color and pack
   assign s4_is_render = (s4_item_ff.kind == KIND_RENDER_IMG) ||
                         (s4_item_ff.kind == KIND_RENDER_BORDER);
   assign color_sel = (s4_item_ff.kind == KIND_RENDER_BORDER) ? cfg.background_color :
                      store_rd_ff;
   assign color_fmt = cfg.mode_bits[MODE_RGB565] ?
                      {8'd0, color_sel[23:19], color_sel[15:10], color_sel[7:3]} : color_sel;
   assign rsp_valid_in = advance ? (s4_valid_ff && s4_is_render) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            s1_valid_ff <= pop_valid;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_item_ff    <= pop_item;
         s2_item_ff    <= s1_item_ff;
         sx_ff         <= x_mirror[COORD_W-1:0];
         sy_ff         <= y_mirror[COORD_W-1:0];
         s3_item_ff    <= s2_item_ff;
         addr_ff       <= addr_in;
         s4_item_ff    <= s3_item_ff;
         rsp_color_ff  <= color_fmt;
         rsp_border_ff <= (s4_item_ff.kind == KIND_RENDER_BORDER);
         rsp_col_ff    <= s4_item_ff.dest_col;
         rsp_row_ff    <= s4_item_ff.dest_row;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_is_border   = rsp_border_ff;
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_out_row     = rsp_row_ff;

endmodule
